// ===== rtl/box_overlap_merge_suppress_defines.svh =====
`ifndef BOX_OVERLAP_MERGE_SUPPRESS_DEFINES_SVH
`define BOX_OVERLAP_MERGE_SUPPRESS_DEFINES_SVH

// Implication in the same cycle, sampled on clk, off during reset.
`define BOM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define BOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bom_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bom_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;
    localparam int EDGE_BITS      = 13;
    localparam int INDEX_BITS     = 6;
    localparam int THR_BITS       = 8;

    localparam logic [THR_BITS-1:0] THR_NUM_RESET = 8'd3;
    localparam logic [THR_BITS-1:0] THR_DEN_RESET = 8'd10;

    localparam logic REG_THR_NUM = 1'b0;
    localparam logic REG_THR_DEN = 1'b1;

    typedef struct packed {
        logic shift;
        logic flush;
        logic drop;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bom_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bom_cell
    import bom_pkg::*;
#(
    parameter int EW = COORD_BITS_DEF + 1,
    parameter int IW = $clog2(MAX_BOXES_DEF)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_ctl_t     ctl,
    input  wire logic [4*EW-1:0] nxt_box,
    input  wire logic          nxt_keep,
    input  wire logic          nxt_valid,
    input  wire logic [IW-1:0] nxt_idx,
    output logic [4*EW-1:0]    box,
    output logic               keep,
    output logic               valid,
    output logic [IW-1:0]      idx
);

    logic [4*EW-1:0] box_reg;
    logic [IW-1:0]   idx_reg;
    logic            keep_reg;
    logic            valid_reg;

    // Payload: take neighbor on shift.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            box_reg <= nxt_box;
            idx_reg <= nxt_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else if (ctl.flush)
        begin
            keep_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            keep_reg  <= nxt_keep & ~ctl.drop;
            valid_reg <= nxt_valid;
        end
        else if (ctl.drop)
        begin
            keep_reg <= 1'b0;
        end
    end

    assign box   = box_reg;
    assign keep  = keep_reg;
    assign valid = valid_reg;
    assign idx   = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/bom_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bom_cmp
    import bom_pkg::*;
#(
    parameter int EW = COORD_BITS_DEF + 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire logic [4*EW-1:0]     run_box,
    input  wire logic [4*EW-1:0]     cand_box,
    input  wire logic [THR_BITS-1:0] thr_num,
    input  wire logic [THR_BITS-1:0] thr_den,
    output logic                     done,
    output logic                     merge
);

    localparam int AW = 2 * EW;
    localparam int UW = AW + 1;
    localparam int PW = UW + THR_BITS;

    // Box packing: {bottom, right, top, left}.
    logic [EW-1:0] rl, rt, rr, rb, cl, ct, cr, cb;
    logic [EW-1:0] x1, y1, x2, y2;

    logic [4:0]    vld_reg;
    logic [EW-1:0] iw_reg, ih_reg, rw_reg, rh_reg, cw_reg, ch_reg;
    logic [AW-1:0] inter_reg, ar_reg, ac_reg, inter3_reg;
    logic [UW-1:0] uni_reg;
    logic [PW-1:0] lhs_reg, rhs_reg;
    logic          merge_reg;

    assign {rb, rr, rt, rl} = run_box;
    assign {cb, cr, ct, cl} = cand_box;

    assign x1 = (rl > cl) ? rl : cl;
    assign y1 = (rt > ct) ? rt : ct;
    assign x2 = (rr < cr) ? rr : cr;
    assign y2 = (rb < cb) ? rb : cb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], go};
        end
    end

    always_ff @(posedge clk)
    begin
        // widths and overlap extents
        iw_reg <= (x2 > x1) ? (x2 - x1) : '0;
        ih_reg <= (y2 > y1) ? (y2 - y1) : '0;
        rw_reg <= rr - rl;
        rh_reg <= rb - rt;
        cw_reg <= cr - cl;
        ch_reg <= cb - ct;
        // areas
        inter_reg <= AW'(iw_reg) * AW'(ih_reg);
        ar_reg    <= AW'(rw_reg) * AW'(rh_reg);
        ac_reg    <= AW'(cw_reg) * AW'(ch_reg);
        // union
        inter3_reg <= inter_reg;
        uni_reg    <= UW'(ar_reg) + UW'(ac_reg) - UW'(inter_reg);
        // scale by the threshold ratio
        lhs_reg <= PW'(inter3_reg) * PW'(thr_den);
        rhs_reg <= PW'(uni_reg) * PW'(thr_num);
        merge_reg <= lhs_reg > rhs_reg;
    end

    assign done  = vld_reg[4];
    assign merge = merge_reg;

endmodule

`default_nettype wire

// ===== rtl/box_overlap_merge_suppress.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Greedy overlap merge over one set of up to MAX_BOXES boxes. Boxes load
// one per cycle (start while busy is low); the box with is_last set closes
// the set and raises busy. The boxes sit in a ring of cells that rotates one
// place a cycle past a single five-stage overlap comparator at its head, and
// holds still while a comparison is in flight. A set is processed by first
// rotating box 0 to the head; a suppressed box then just passes on, while a
// kept box goes round the whole ring, waiting on the comparator for every
// later box. Each box's result leaves on result_valid for one cycle as soon
// as that box is resolved, in load order; the last result shows in the first
// idle cycle. There is no backpressure, so the receiver must take every
// result when it is shown. Threshold registers are written through the cfg
// port only while idle.

`include "box_overlap_merge_suppress_defines.svh"

module box_overlap_merge_suppress
    import bom_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] box_x,
    input  wire logic [COORD_BITS-1:0] box_y,
    input  wire logic [COORD_BITS-1:0] box_w,
    input  wire logic [COORD_BITS-1:0] box_h,
    input  wire logic                  is_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [THR_BITS-1:0]   cfg_data,
    output logic                       result_valid,
    output logic [INDEX_BITS-1:0]      box_index,
    output logic                       keep,
    output logic [EDGE_BITS-1:0]       left,
    output logic [EDGE_BITS-1:0]       top,
    output logic [EDGE_BITS-1:0]       right,
    output logic [EDGE_BITS-1:0]       bottom,
    output logic                       overflow,
    output logic                       last_result
);

    localparam int EW = COORD_BITS + 1;
    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_PICK,
        ST_SCAN,
        ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pass_reg, pass_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [4*EW-1:0] run_reg, run_next;
    logic [THR_BITS-1:0] num_reg, num_next, den_reg, den_next;

    logic                  res_vld_reg, res_vld_next;
    logic [CW-1:0]         res_idx_reg, res_idx_next;
    logic                  res_keep_reg, res_keep_next;
    logic [4*EW-1:0]       res_box_reg, res_box_next;
    logic                  res_ovf_reg, res_ovf_next;
    logic                  res_last_reg, res_last_next;

    // ring of cells
    cell_ctl_t       ctl [MAX_BOXES];
    logic [4*EW-1:0] c_box   [MAX_BOXES];
    logic            c_keep  [MAX_BOXES];
    logic            c_valid [MAX_BOXES];
    logic [IW-1:0]   c_idx   [MAX_BOXES];

    logic            load, rotate, flush, drop_head, cmp_go;
    logic            cmp_done, cmp_merge;
    logic [4*EW-1:0] new_box;
    logic [4*EW-1:0] tail_box;
    logic            tail_keep, tail_valid;
    logic [IW-1:0]   tail_idx;
    logic            head_later;
    logic [4*EW-1:0] merged;
    logic [EW-1:0]   rl, rt, rr, rb, hl, ht, hr, hb;
    logic            last_pass;

    assign new_box = {EW'(box_y) + EW'(box_h), EW'(box_x) + EW'(box_w),
                      EW'(box_y), EW'(box_x)};

    // Tail takes the incoming box on load, otherwise the head wraps around.
    assign tail_box   = load ? new_box : c_box[0];
    assign tail_keep  = load ? 1'b1 : c_keep[0];
    assign tail_valid = load ? 1'b1 : c_valid[0];
    assign tail_idx   = load ? IW'(count_reg) : c_idx[0];

    for (genvar k = 0; k < MAX_BOXES; k++)
    begin : g_cell
        assign ctl[k].shift = load | rotate;
        assign ctl[k].flush = flush;
        // The head box wraps into the tail cell, so clear its keep flag there.
        assign ctl[k].drop  = (k == MAX_BOXES - 1) ? drop_head : 1'b0;
        if (k == MAX_BOXES - 1)
        begin : g_tail
            bom_cell #(.EW(EW), .IW(IW)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[k]),
                .nxt_box   (tail_box),
                .nxt_keep  (tail_keep),
                .nxt_valid (tail_valid),
                .nxt_idx   (tail_idx),
                .box       (c_box[k]),
                .keep      (c_keep[k]),
                .valid     (c_valid[k]),
                .idx       (c_idx[k])
            );
        end
        else
        begin : g_mid
            bom_cell #(.EW(EW), .IW(IW)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[k]),
                .nxt_box   (c_box[k+1]),
                .nxt_keep  (c_keep[k+1]),
                .nxt_valid (c_valid[k+1]),
                .nxt_idx   (c_idx[k+1]),
                .box       (c_box[k]),
                .keep      (c_keep[k]),
                .valid     (c_valid[k]),
                .idx       (c_idx[k])
            );
        end
    end

    bom_cmp #(.EW(EW)) u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmp_go),
        .run_box  (run_reg),
        .cand_box (c_box[0]),
        .thr_num  (num_reg),
        .thr_den  (den_reg),
        .done     (cmp_done),
        .merge    (cmp_merge)
    );

    // Bounding union of the running box and the head box.
    assign {rb, rr, rt, rl} = run_reg;
    assign {hb, hr, ht, hl} = c_box[0];
    assign merged = {(rb > hb) ? rb : hb, (rr > hr) ? rr : hr,
                     (rt < ht) ? rt : ht, (rl < hl) ? rl : hl};

    assign head_later = c_valid[0] && (CW'(c_idx[0]) > pass_reg);
    assign last_pass  = (pass_reg == count_reg - CW'(1));

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        run_next   = run_reg;
        num_next   = num_reg;
        den_next   = den_reg;

        res_vld_next  = 1'b0;
        res_idx_next  = pass_reg;
        res_keep_next = c_keep[0];
        res_box_next  = c_box[0];
        res_ovf_next  = ovf_reg;
        res_last_next = last_pass;

        load      = 1'b0;
        rotate    = 1'b0;
        flush     = 1'b0;
        drop_head = 1'b0;
        cmp_go    = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THR_NUM: num_next = cfg_data;
                REG_THR_DEN: den_next = cfg_data;
                default:     num_next = num_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Store while room is left, otherwise drop and flag.
                    if (count_reg < MAX_CNT)
                    begin
                        load       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_ALIGN;
                        cnt_next   = MAX_CNT - count_next;
                        pass_next  = '0;
                    end
                end
            end
            ST_ALIGN:
            begin
                // Rotate until box 0 sits at the head.
                if (cnt_reg == '0)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    rotate   = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_PICK:
            begin
                rotate = 1'b1;
                if (!c_keep[0])
                begin
                    // Suppressed box: show its own corners right away.
                    res_vld_next = 1'b1;
                    if (last_pass)
                    begin
                        flush      = 1'b1;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pass_next = pass_reg + CW'(1);
                    end
                end
                else
                begin
                    run_next   = c_box[0];
                    cnt_next   = MAX_CNT - CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    // Kept box is back at the head: show the merged box.
                    rotate        = 1'b1;
                    res_vld_next  = 1'b1;
                    res_keep_next = 1'b1;
                    res_box_next  = run_reg;
                    if (last_pass)
                    begin
                        flush      = 1'b1;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pass_next  = pass_reg + CW'(1);
                        state_next = ST_PICK;
                    end
                end
                else if (head_later)
                begin
                    cmp_go     = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    rotate   = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_WAIT:
            begin
                if (cmp_done)
                begin
                    rotate   = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                    if (cmp_merge)
                    begin
                        drop_head = 1'b1;
                        run_next  = merged;
                    end
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pass_reg    <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            run_reg     <= '0;
            num_reg     <= THR_NUM_RESET;
            den_reg     <= THR_DEN_RESET;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pass_reg    <= pass_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            run_reg     <= run_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Result payload: hold until the next result.
    always_ff @(posedge clk)
    begin
        if (res_vld_next)
        begin
            res_idx_reg  <= res_idx_next;
            res_keep_reg <= res_keep_next;
            res_box_reg  <= res_box_next;
            res_ovf_reg  <= res_ovf_next;
            res_last_reg <= res_last_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign box_index    = INDEX_BITS'(res_idx_reg);
    assign keep         = res_keep_reg;
    assign left         = EDGE_BITS'(res_box_reg[EW-1:0]);
    assign top          = EDGE_BITS'(res_box_reg[2*EW-1:EW]);
    assign right        = EDGE_BITS'(res_box_reg[3*EW-1:2*EW]);
    assign bottom       = EDGE_BITS'(res_box_reg[4*EW-1:3*EW]);
    assign overflow     = res_ovf_reg;
    assign last_result  = res_last_reg;

    `BOM_ASSERT_SAME(a_last_idle, result_valid && last_result, !busy, "last result while busy")
    `BOM_ASSERT_SAME(a_cmp_scan, cmp_go, state_reg == ST_SCAN && head_later, "bad compare start")
    `BOM_ASSERT_NEXT(a_load_idle, start && !busy && !is_last, !busy, "busy after plain load")
    `BOM_ASSERT_SAME(a_count_cap, 1'b1, count_reg <= MAX_CNT, "box count over capacity")

endmodule

`default_nettype wire

// ===== tb/box_merge_checker.sv =====
`timescale 1ns / 1ps

// Watches the box, config and result channels of box_overlap_merge_suppress,
// predicts every result of a closed box set and compares it in order.
module box_merge_checker
    import bom_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [11:0]           box_x,
    input  logic [11:0]           box_y,
    input  logic [11:0]           box_w,
    input  logic [11:0]           box_h,
    input  logic                  is_last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [THR_BITS-1:0]   cfg_data,
    input  logic                  result_valid,
    input  logic [INDEX_BITS-1:0] box_index,
    input  logic                  keep,
    input  logic [EDGE_BITS-1:0]  left,
    input  logic [EDGE_BITS-1:0]  top,
    input  logic [EDGE_BITS-1:0]  right,
    input  logic [EDGE_BITS-1:0]  bottom,
    input  logic                  overflow,
    input  logic                  last_result,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen,
    output int                    sets_seen,
    output int                    merges_seen
);

    typedef struct packed {
        logic [EDGE_BITS-1:0] l;
        logic [EDGE_BITS-1:0] t;
        logic [EDGE_BITS-1:0] r;
        logic [EDGE_BITS-1:0] b;
    } rect_t;

    typedef struct {
        logic [INDEX_BITS-1:0] idx;
        logic                  kept;
        rect_t                 corners;
        logic                  ovf;
        logic                  fin;
    } merged_box_t;

    rect_t         loaded[MAX_BOXES_DEF];
    int            loaded_count;
    logic          dropped_any;
    logic [7:0]    thr_num;
    logic [7:0]    thr_den;
    merged_box_t   merged_q[$];

    assign pending = merged_q.size();

    function automatic bit overlaps_enough(rect_t a, rect_t c);
        longint unsigned x1, y1, x2, y2, iw, ih, inter, uni;
        x1 = (a.l > c.l) ? a.l : c.l;
        y1 = (a.t > c.t) ? a.t : c.t;
        x2 = (a.r < c.r) ? a.r : c.r;
        y2 = (a.b < c.b) ? a.b : c.b;
        iw = (x2 > x1) ? x2 - x1 : 0;
        ih = (y2 > y1) ? y2 - y1 : 0;
        inter = iw * ih;
        uni = longint'(a.r - a.l) * longint'(a.b - a.t)
            + longint'(c.r - c.l) * longint'(c.b - c.t) - inter;
        return inter * thr_den > longint'(thr_num) * uni;
    endfunction

    // Greedy merge over the loaded set; queue one result per box.
    task automatic merge_set();
        bit          kept[MAX_BOXES_DEF];
        rect_t       shown[MAX_BOXES_DEF];
        rect_t       run;
        merged_box_t m;
        for (int i = 0; i < loaded_count; i++)
            kept[i] = 1'b1;
        for (int i = 0; i < loaded_count; i++)
        begin
            shown[i] = loaded[i];
            if (kept[i])
            begin
                run = loaded[i];
                for (int j = i + 1; j < loaded_count; j++)
                begin
                    if (overlaps_enough(run, loaded[j]))
                    begin
                        kept[j] = 1'b0;
                        merges_seen++;
                        if (loaded[j].l < run.l) run.l = loaded[j].l;
                        if (loaded[j].t < run.t) run.t = loaded[j].t;
                        if (loaded[j].r > run.r) run.r = loaded[j].r;
                        if (loaded[j].b > run.b) run.b = loaded[j].b;
                    end
                end
                shown[i] = run;
            end
        end
        for (int i = 0; i < loaded_count; i++)
        begin
            m.idx     = i[INDEX_BITS-1:0];
            m.kept    = kept[i];
            m.corners = shown[i];
            m.ovf     = dropped_any;
            m.fin     = (i + 1 == loaded_count);
            merged_q  = {merged_q, m};
        end
        sets_seen++;
        loaded_count = 0;
        dropped_any  = 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        merged_box_t m;
        rect_t       nb;
        if (!rst_n)
        begin
            loaded_count = 0;
            dropped_any  = 1'b0;
            thr_num      = THR_NUM_RESET;
            thr_den      = THR_DEN_RESET;
            merged_q.delete();
        end
        else
        begin
            // Results first: a set closed at this edge cannot answer yet.
            if (result_valid)
            begin
                results_seen++;
                if (merged_q.size() == 0)
                begin
                    $error("result for box %0d with none expected", box_index);
                    fail_count++;
                end
                else
                begin
                    m = merged_q.pop_front();
                    check_field("box_index", m.idx, box_index);
                    check_field("keep", m.kept, keep);
                    check_field("left", m.corners.l, left);
                    check_field("top", m.corners.t, top);
                    check_field("right", m.corners.r, right);
                    check_field("bottom", m.corners.b, bottom);
                    check_field("overflow", m.ovf, overflow);
                    check_field("last_result", m.fin, last_result);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_THR_NUM)
                    thr_num = cfg_data;
                else
                    thr_den = cfg_data;
            end
            if (start && !busy)
            begin
                if (loaded_count < MAX_BOXES_DEF)
                begin
                    nb.l = {1'b0, box_x};
                    nb.t = {1'b0, box_y};
                    nb.r = box_x + box_w;
                    nb.b = box_y + box_h;
                    loaded[loaded_count] = nb;
                    loaded_count++;
                end
                else
                    dropped_any = 1'b1;
                if (is_last)
                    merge_set();
            end
        end
    end

    initial
    begin
        fail_count   = 0;
        results_seen = 0;
        sets_seen    = 0;
        merges_seen  = 0;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for box_overlap_merge_suppress. The checker beside the
// block does all prediction; this module only loads box sets, rewrites the
// overlap thresholds between sets and decides pass or fail.
module tb;
    import bom_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [11:0]           box_x;
    logic [11:0]           box_y;
    logic [11:0]           box_w;
    logic [11:0]           box_h;
    logic                  is_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [THR_BITS-1:0]   cfg_data;
    logic                  result_valid;
    logic [INDEX_BITS-1:0] box_index;
    logic                  keep;
    logic [EDGE_BITS-1:0]  left;
    logic [EDGE_BITS-1:0]  top;
    logic [EDGE_BITS-1:0]  right;
    logic [EDGE_BITS-1:0]  bottom;
    logic                  overflow;
    logic                  last_result;

    int fail_count;
    int pending;
    int results_seen;
    int sets_seen;
    int merges_seen;
    int boxes_sent;
    int gap_pct;

    box_overlap_merge_suppress dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .box_x        (box_x),
        .box_y        (box_y),
        .box_w        (box_w),
        .box_h        (box_h),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .box_index    (box_index),
        .keep         (keep),
        .left         (left),
        .top          (top),
        .right        (right),
        .bottom       (bottom),
        .overflow     (overflow),
        .last_result  (last_result)
    );

    box_merge_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .box_x        (box_x),
        .box_y        (box_y),
        .box_w        (box_w),
        .box_h        (box_h),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .box_index    (box_index),
        .keep         (keep),
        .left         (left),
        .top          (top),
        .right        (right),
        .bottom       (bottom),
        .overflow     (overflow),
        .last_result  (last_result),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .sets_seen    (sets_seen),
        .merges_seen  (merges_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one box request and hold it until the block takes it. On return
    // start is still high, so the next request can follow back to back.
    task automatic send_box(input logic [11:0] x, input logic [11:0] y,
                            input logic [11:0] w, input logic [11:0] h,
                            input logic fin);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        start   <= 1'b1;
        box_x   <= x;
        box_y   <= y;
        box_w   <= w;
        box_h   <= h;
        is_last <= fin;
        do
            @(posedge clk);
        while (busy);
        boxes_sent++;
    endtask

    // Drain all results, let the block settle, then write both thresholds.
    task automatic set_thresholds(input logic [7:0] num, input logic [7:0] den);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_THR_NUM;
        cfg_data  <= num;
        do
            @(posedge clk);
        while (!cfg_ready);
        // Keep valid high; move straight on to the denominator.
        cfg_index <= REG_THR_DEN;
        cfg_data  <= den;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random set: mostly boxes clustered around a center so that they
    // overlap and merge, with some full-range noise boxes mixed in.
    task automatic random_set(input int n);
        logic [11:0] cx, cy, x, y, w, h;
        int          spread;
        cx     = 12'($urandom_range(4095));
        cy     = 12'($urandom_range(4095));
        spread = $urandom_range(1, 200);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 80)
            begin
                x = 12'(cx + $urandom_range(spread));
                y = 12'(cy + $urandom_range(spread));
                w = 12'($urandom_range(spread * 2));
                h = 12'($urandom_range(spread * 2));
            end
            else
            begin
                x = 12'($urandom);
                y = 12'($urandom);
                w = 12'($urandom);
                h = 12'($urandom);
            end
            send_box(x, y, w, h, i == n - 1);
        end
    endtask

    initial
    begin
        int set_size;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        box_x      <= '0;
        box_y      <= '0;
        box_w      <= '0;
        box_h      <= '0;
        is_last    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_THR_NUM;
        cfg_data   <= '0;
        boxes_sent = 0;
        gap_pct    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset thresholds: lone box at the far corner.
        send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
        // Identical boxes merge; an empty box never does; a disjoint box stays.
        send_box(12'd100, 12'd100, 12'd50, 12'd50, 1'b0);
        send_box(12'd100, 12'd100, 12'd50, 12'd50, 1'b0);
        send_box(12'd110, 12'd110, 12'd0, 12'd0, 1'b0);
        send_box(12'd0, 12'd0, 12'd0, 12'hFFF, 1'b0);
        send_box(12'd3000, 12'd10, 12'd20, 12'd20, 1'b1);
        // Chain: box two merges into box one; box three then overlaps too little.
        send_box(12'd0, 12'd0, 12'd100, 12'd100, 1'b0);
        send_box(12'd40, 12'd0, 12'd100, 12'd100, 1'b0);
        send_box(12'd90, 12'd0, 12'd100, 12'd100, 1'b0);
        send_box(12'd0, 12'd0, 12'hFFF, 12'hFFF, 1'b1);

        // Extremes of the thresholds: any overlap merges / nothing merges.
        set_thresholds(8'd0, 8'd1);
        random_set(6);
        set_thresholds(8'd255, 8'd255);
        random_set(6);
        // Zero denominator: no merge at all.
        set_thresholds(8'd0, 8'd0);
        random_set(5);

        // Overflow: more boxes than the store holds; the dropped last box
        // still closes the set.
        set_thresholds(8'd1, 8'd4);
        random_set(MAX_BOXES_DEF + 2);

        // Random sets in three pacing phases, thresholds changed between.
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
            set_thresholds(8'($urandom_range(255)), 8'($urandom_range(1, 255)));
            while (boxes_sent < 180 + phase * 120)
            begin
                if ($urandom_range(99) < 25)
                    set_thresholds(8'($urandom_range(10)), 8'($urandom_range(1, 20)));
                set_size = ($urandom_range(9) == 0) ? $urandom_range(13, 30)
                                                    : $urandom_range(1, 12);
                random_set(set_size);
            end
        end
        set_thresholds(THR_NUM_RESET, THR_DEN_RESET);
        random_set(10);

        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (50) @(posedge clk);

        $display("Loaded %0d boxes in %0d sets; checked %0d results, %0d merges.",
                 boxes_sent, sets_seen, results_seen, merges_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== box_overlap_merge_suppress.f =====
+incdir+rtl
rtl/bom_pkg.sv
rtl/bom_cell.sv
rtl/bom_cmp.sv
rtl/box_overlap_merge_suppress.sv
tb/box_merge_checker.sv
tb/tb.sv
